// ----- rtl/kdc_pkg.sv -----
// shared types and constants of the key double-click classifier
// no dependencies; imported by kdc_core, kdc_out_fifo and the top level
package kdc_pkg;

  localparam int unsigned KeyCountDefault    = 8;
  localparam logic [15:0] ClickWindowReset   = 16'd30;
  localparam int unsigned OutDepth           = 4;

  typedef enum logic {
    REQ_REPORT = 1'b0,
    REQ_TICK   = 1'b1
  } kdc_req_e;

  typedef enum logic [1:0] {
    RAW_RELEASE = 2'd0,
    RAW_PRESS   = 2'd1,
    RAW_LONG    = 2'd2,
    RAW_REPEAT  = 2'd3
  } kdc_raw_e;

  typedef enum logic [2:0] {
    EV_DOWN    = 3'd0,
    EV_UP      = 3'd1,
    EV_LONG    = 3'd2,
    EV_REPEAT  = 3'd3,
    EV_RELEASE = 3'd4,
    EV_DOUBLE  = 3'd5
  } kdc_event_e;

  typedef struct packed {
    logic [2:0] key;
    kdc_event_e event_code;
    logic       last;
  } kdc_result_t;

  // results of one request, pushed together into the output queue
  typedef struct packed {
    logic [1:0]  count;
    kdc_result_t first;
    kdc_result_t second;
  } kdc_push_t;

endpackage

// ----- rtl/kdc_core.sv -----
// classification logic and hold state of the key double-click classifier
// depends on kdc_pkg
module kdc_core #(
  parameter int unsigned KEY_COUNT = kdc_pkg::KeyCountDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              req_type_i,
  input  logic [2:0]        key_index_i,
  input  logic [1:0]        raw_state_i,
  input  logic [15:0]       click_window_i,
  output kdc_pkg::kdc_push_t push_o
);
  import kdc_pkg::*;

  logic [2:0]  held_key_q, held_key_d;
  logic        held_valid_q, held_valid_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic        running_q, running_d;
  logic        double_q, double_d;
  logic        long_seen_q, long_seen_d;

  kdc_push_t   push;
  kdc_event_e  ev;
  logic        same;
  logic        key_ok;
  logic [15:0] elapsed_inc;

  assign key_ok = 32'(key_index_i) < 32'(KEY_COUNT);
  assign same   = held_valid_q && (held_key_q == key_index_i);
  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;

  always_comb begin
    held_key_d   = held_key_q;
    held_valid_d = held_valid_q;
    elapsed_d    = elapsed_q;
    running_d    = running_q;
    double_d     = double_q;
    long_seen_d  = long_seen_q;
    push         = '0;
    ev           = EV_REPEAT;

    unique case (kdc_raw_e'(raw_state_i))
      RAW_RELEASE: ev = long_seen_q ? EV_RELEASE : EV_UP;
      RAW_PRESS:   ev = EV_DOWN;
      RAW_LONG:    ev = EV_LONG;
      RAW_REPEAT:  ev = EV_REPEAT;
      default:     ev = EV_REPEAT;
    endcase

    if (kdc_req_e'(req_type_i) == REQ_TICK) begin
      if (running_q && held_valid_q) begin
        elapsed_d = elapsed_inc;
        if (elapsed_inc >= click_window_i) begin
          push.count = 2'd1;
          push.first = '{key: held_key_q, event_code: EV_UP, last: 1'b0};
          held_valid_d = 1'b0;
          running_d    = 1'b0;
          double_d     = 1'b0;
          elapsed_d    = '0;
        end
      end
    end else if (key_ok) begin
      unique case (kdc_raw_e'(raw_state_i))
        RAW_RELEASE, RAW_PRESS: long_seen_d = 1'b0;
        RAW_LONG:               long_seen_d = 1'b1;
        default:                long_seen_d = long_seen_q;
      endcase

      if (ev == EV_UP || ev == EV_RELEASE) begin
        if (same && double_q) begin
          push.count = 2'd1;
          push.first = '{key: key_index_i, event_code: EV_DOUBLE, last: 1'b0};
          held_valid_d = 1'b0;
          running_d    = 1'b0;
          double_d     = 1'b0;
          elapsed_d    = '0;
        end else if (ev == EV_UP) begin
          // another key was held: its up goes out now
          if (held_valid_q && !same) begin
            push.count = 2'd1;
            push.first = '{key: held_key_q, event_code: EV_UP, last: 1'b0};
          end
          held_key_d   = key_index_i;
          held_valid_d = 1'b1;
          elapsed_d    = '0;
          running_d    = 1'b1;
          double_d     = 1'b0;
        end else begin
          if (held_valid_q) begin
            push.count  = 2'd2;
            push.first  = '{key: held_key_q, event_code: EV_UP, last: 1'b0};
            push.second = '{key: key_index_i, event_code: EV_RELEASE, last: 1'b0};
          end else begin
            push.count = 2'd1;
            push.first = '{key: key_index_i, event_code: EV_RELEASE, last: 1'b0};
          end
          held_valid_d = 1'b0;
          running_d    = 1'b0;
          double_d     = 1'b0;
          elapsed_d    = '0;
        end
      end else if (ev == EV_DOWN) begin
        if (same && (double_q || elapsed_q <= click_window_i)) begin
          double_d  = 1'b1;
          running_d = 1'b0;
        end else begin
          if (held_valid_q) begin
            push.count  = 2'd2;
            push.first  = '{key: held_key_q, event_code: EV_UP, last: 1'b0};
            push.second = '{key: key_index_i, event_code: EV_DOWN, last: 1'b0};
          end else begin
            push.count = 2'd1;
            push.first = '{key: key_index_i, event_code: EV_DOWN, last: 1'b0};
          end
          held_valid_d = 1'b0;
          running_d    = 1'b0;
          double_d     = 1'b0;
          elapsed_d    = '0;
        end
      end else if (!(same && double_q)) begin
        push.count = 2'd1;
        push.first = '{key: key_index_i, event_code: ev, last: 1'b0};
      end
    end

    push.first.last  = (push.count == 2'd1);
    push.second.last = 1'b1;
  end

  assign push_o = accept_i ? push : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_key_q   <= '0;
      held_valid_q <= 1'b0;
      elapsed_q    <= '0;
      running_q    <= 1'b0;
      double_q     <= 1'b0;
      long_seen_q  <= 1'b0;
    end else if (accept_i) begin
      held_key_q   <= held_key_d;
      held_valid_q <= held_valid_d;
      elapsed_q    <= elapsed_d;
      running_q    <= running_d;
      double_q     <= double_d;
      long_seen_q  <= long_seen_d;
    end
  end

endmodule

// ----- rtl/kdc_out_fifo.sv -----
// result queue: takes up to two results a cycle, hands out one while out_ready_i is high
// depends on kdc_pkg
module kdc_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kdc_pkg::kdc_push_t   push_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output kdc_pkg::kdc_result_t out_data_o
);
  import kdc_pkg::*;

  localparam int unsigned PtrW = $clog2(OutDepth);
  localparam int unsigned CntW = $clog2(OutDepth + 1);

  kdc_result_t         mem_q [OutDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                pop;
  logic [PtrW-1:0]     wr_next;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = count_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];
  // room for a full two-result request
  assign room_o      = count_q <= CntW'(OutDepth - 2);
  assign wr_next     = wr_ptr_q + PtrW'(1);

  assign wr_ptr_d = wr_ptr_q + PtrW'(push_i.count);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign count_d  = count_q + CntW'(push_i.count) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- rtl/key_double_click_classifier.sv -----
// top level of the key double-click classifier
// depends on kdc_pkg, kdc_core and kdc_out_fifo
//
// Turns keypad reports and time ticks into key events (down, up, long press,
// repeat, release, double click). The first up of a key is held back for
// click_window ticks; a second press of the same key inside the window
// suppresses its down, long press and repeat, and its next up or release
// comes out as a double click. A held up leaves when the window expires or
// when another key goes down, up or releases. Classification and the hold
// state update happen in the cycle that accepts a request, and any resulting
// events (at most two) go into a four-entry result queue that feeds the
// output channel one event per cycle while out_ready_i is high; the events
// of a request leave the queue after any earlier events, in order.
// Requests are taken every cycle while the queue has room for two events; a
// run of two-event requests outpaces the one-event-per-cycle output, and
// in_ready_o then stays low until two queue entries are free again.
// last_of_run_o marks the final event of each request.
// Reports with a key at or above KEY_COUNT are dropped. click_window is
// written through the cfg channel, always ready, and resets to 30.
module key_double_click_classifier #(
  parameter int unsigned KEY_COUNT = kdc_pkg::KeyCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [2:0]  key_index_i,
  input  logic [1:0]  raw_state_i,
  // event channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  out_key_o,
  output logic [2:0]  out_event_o,
  output logic        last_of_run_o,
  // click window register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] click_window_i
);
  import kdc_pkg::*;

  logic [15:0] click_window_q;
  logic        accept;
  kdc_push_t   push;
  kdc_result_t result;

  assign cfg_ready_o = 1'b1;

  // window length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      click_window_q <= ClickWindowReset;
    end else if (cfg_valid_i) begin
      click_window_q <= click_window_i;
    end
  end

  assign accept = in_valid_i && in_ready_o;

  // classification and hold state
  kdc_core #(
    .KEY_COUNT (KEY_COUNT)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .req_type_i     (req_type_i),
    .key_index_i    (key_index_i),
    .raw_state_i    (raw_state_i),
    .click_window_i (click_window_q),
    .push_o         (push)
  );

  // result queue decoupling the output side
  kdc_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (result)
  );

  assign out_key_o     = result.key;
  assign out_event_o   = result.event_code;
  assign last_of_run_o = result.last;

endmodule
